// ===== hw/rtl/interlaced_palette_pixel_writer_assert.svh =====
// Assertion macros shared by the pixel writer RTL.
// Every check is sampled on the rising clock edge and held off during reset.
`ifndef INTERLACED_PALETTE_PIXEL_WRITER_ASSERT_SVH
`define INTERLACED_PALETTE_PIXEL_WRITER_ASSERT_SVH

// Plain property check.
`define IPPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define IPPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ippw_pkg.sv =====
package ippw_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned CoordBitsDef    = 16;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_FRAME_LEFT    = 3'd2;
  localparam logic [2:0] REG_FRAME_TOP     = 3'd3;
  localparam logic [2:0] REG_INTERLACE_ON  = 3'd4;
  localparam logic [2:0] REG_TRANSP_ON     = 3'd5;
  localparam logic [2:0] REG_TRANSP_INDEX  = 3'd6;
  localparam logic [2:0] REG_PAL_ENTRIES   = 3'd7;

  // Interlace passes and their starting rows and row steps.
  localparam logic [1:0] PASS_FIRST  = 2'd0;
  localparam logic [1:0] PASS_SECOND = 2'd1;
  localparam logic [1:0] PASS_THIRD  = 2'd2;
  localparam logic [1:0] PASS_LAST   = 2'd3;

  localparam logic [16:0] ROW_SECOND = 17'd4;
  localparam logic [16:0] ROW_THIRD  = 17'd2;
  localparam logic [16:0] ROW_LAST   = 17'd1;

  localparam logic [3:0] STEP_FIRST  = 4'd8;
  localparam logic [3:0] STEP_SECOND = 4'd8;
  localparam logic [3:0] STEP_THIRD  = 4'd4;
  localparam logic [3:0] STEP_LAST   = 4'd2;

  // Alpha values.
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Register reset values.
  localparam logic [15:0] FRAME_WIDTH_RST  = 16'd1;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd1;
  localparam logic [8:0]  PAL_ENTRIES_RST  = 9'd256;

endpackage

// ===== hw/rtl/interlaced_palette_pixel_writer.sv =====
// Pipeline: a pixel result passes the palette memory read register, then the output
//   register, before it is offered on the master side. Throughput: one transaction
//   per cycle unless the output stalls, limited by the single palette read port.
// Reset: the position and the pipeline are cleared and every configuration register
//   takes its reset value at once; palette entries hold no defined value until loaded.
`include "interlaced_palette_pixel_writer_assert.svh"

module interlaced_palette_pixel_writer #(
  parameter int unsigned PALETTE_DEPTH = ippw_pkg::PaletteDepthDef,
  parameter int unsigned COORD_BITS    = ippw_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_addr_i,
  input  logic [15:0]          cfg_data_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // color_index[7:0], load_red[15:8], load_green[23:16], load_blue[31:24]
  input  logic [31:0]          s_axis_tdata,
  // command[1:0]
  input  logic [1:0]           s_axis_tuser,
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // screen_row, screen_column (COORD_BITS each), pixel_red, pixel_green,
  // pixel_blue, pixel_alpha (8 bits each), zero fill to whole bytes
  output logic [((2*COORD_BITS+32+7)/8)*8-1:0] m_axis_tdata,
  // bad_pixel[0]
  output logic                 m_axis_tuser
);

  localparam int unsigned AddrBits = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned TdataW   = ((2*COORD_BITS+32+7)/8)*8;
  localparam logic [8:0]  DepthLim = 9'(PALETTE_DEPTH);

  // Configuration registers.
  logic [15:0] frame_width_q, frame_height_q, frame_left_q, frame_top_q;
  logic        interlace_on_q, transp_on_q;
  logic [7:0]  transp_index_q;
  logic [8:0]  pal_entries_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ippw_pkg::FRAME_WIDTH_RST;
      frame_height_q <= ippw_pkg::FRAME_HEIGHT_RST;
      frame_left_q   <= '0;
      frame_top_q    <= '0;
      interlace_on_q <= 1'b0;
      transp_on_q    <= 1'b0;
      transp_index_q <= '0;
      pal_entries_q  <= ippw_pkg::PAL_ENTRIES_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        ippw_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        ippw_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        ippw_pkg::REG_FRAME_LEFT:   frame_left_q   <= cfg_data_i;
        ippw_pkg::REG_FRAME_TOP:    frame_top_q    <= cfg_data_i;
        ippw_pkg::REG_INTERLACE_ON: interlace_on_q <= cfg_data_i[0];
        ippw_pkg::REG_TRANSP_ON:    transp_on_q    <= cfg_data_i[0];
        ippw_pkg::REG_TRANSP_INDEX: transp_index_q <= cfg_data_i[7:0];
        ippw_pkg::REG_PAL_ENTRIES:  pal_entries_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Input decode.
  logic        s_acc;
  logic [7:0]  in_code;
  logic [23:0] in_rgb;
  logic        is_load, is_pixel, is_start;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign in_code  = s_axis_tdata[7:0];
  assign in_rgb   = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
  assign is_load  = (s_axis_tuser == ippw_pkg::CMD_LOAD);
  assign is_pixel = (s_axis_tuser == ippw_pkg::CMD_PIXEL);
  assign is_start = (s_axis_tuser == ippw_pkg::CMD_START);

  // Frame position.
  logic [15:0] cur_col_q, nxt_col, col_inc;
  logic [16:0] cur_row_q, nxt_row;
  logic [1:0]  pass_q, nxt_pass;
  logic [3:0]  step_q, nxt_step;

  // A pixel is rejected for an out-of-range code or a position outside the frame.
  logic code_bad, pos_bad, pix_bad;

  assign code_bad = ({1'b0, in_code} >= pal_entries_q) || ({1'b0, in_code} >= DepthLim);
  assign pos_bad  = (cur_row_q >= {1'b0, frame_height_q}) || (cur_col_q >= frame_width_q);
  assign pix_bad  = code_bad || pos_bad;

  // Next position after a good pixel, including the interlace pass hops.
  always_comb begin
    nxt_col  = cur_col_q;
    nxt_row  = cur_row_q;
    nxt_pass = pass_q;
    nxt_step = step_q;
    col_inc  = cur_col_q + 16'd1;
    if (col_inc != frame_width_q) begin
      nxt_col = col_inc;
    end else begin
      nxt_col = '0;
      if (!interlace_on_q) begin
        nxt_row = cur_row_q + 17'd1;
      end else begin
        nxt_row = cur_row_q + 17'(step_q);
        for (int i = 0; i < 3; i++) begin
          if ((nxt_row >= {1'b0, frame_height_q}) && (nxt_pass != ippw_pkg::PASS_LAST)) begin
            nxt_pass = nxt_pass + 2'd1;
            unique case (nxt_pass)
              ippw_pkg::PASS_SECOND: begin
                nxt_row  = ippw_pkg::ROW_SECOND;
                nxt_step = ippw_pkg::STEP_SECOND;
              end
              ippw_pkg::PASS_THIRD: begin
                nxt_row  = ippw_pkg::ROW_THIRD;
                nxt_step = ippw_pkg::STEP_THIRD;
              end
              default: begin
                nxt_row  = ippw_pkg::ROW_LAST;
                nxt_step = ippw_pkg::STEP_LAST;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      pass_q    <= ippw_pkg::PASS_FIRST;
      step_q    <= ippw_pkg::STEP_FIRST;
    end else if (s_acc && is_start) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      pass_q    <= ippw_pkg::PASS_FIRST;
      step_q    <= ippw_pkg::STEP_FIRST;
    end else if (s_acc && is_pixel && !pix_bad) begin
      cur_col_q <= nxt_col;
      cur_row_q <= nxt_row;
      pass_q    <= nxt_pass;
      step_q    <= nxt_step;
    end
  end

  // Palette memory: one write port for loads, one registered read port for pixels.
  // A load is written at its own edge, so a pixel right behind it reads the new entry.
  logic [23:0] palette_mem [PALETTE_DEPTH];
  logic [23:0] pal_rd_q;

  always_ff @(posedge clk_i) begin
    if (s_acc && is_load && ({1'b0, in_code} < DepthLim)) begin
      palette_mem[in_code[AddrBits-1:0]] <= in_rgb;
    end
    if (s_acc && is_pixel && !pix_bad) begin
      pal_rd_q <= palette_mem[in_code[AddrBits-1:0]];
    end
  end

  // Read stage: pixel side data waits here for the palette read.
  logic                  s1_v_q, s1_v_d;
  logic                  s1_bad_q;
  logic [COORD_BITS-1:0] s1_row_q, s1_col_q;
  logic [7:0]            s1_alpha_q;
  logic                  s1_move;

  // Output register.
  logic                  out_v_q, out_v_d;
  logic                  out_bad_q;
  logic [COORD_BITS-1:0] out_row_q, out_col_q;
  logic [23:0]           out_rgb_q;
  logic [7:0]            out_alpha_q;

  assign s1_move       = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_move;

  always_comb begin
    s1_v_d = s1_v_q;
    if (s_acc) begin
      s1_v_d = is_pixel;
    end else if (s1_move) begin
      s1_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (s1_move) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Screen coordinates and alpha are settled in the read stage.
  always_ff @(posedge clk_i) begin
    if (s_acc && is_pixel) begin
      s1_bad_q <= pix_bad;
      if (pix_bad) begin
        s1_row_q   <= '0;
        s1_col_q   <= '0;
        s1_alpha_q <= ippw_pkg::ALPHA_CLEAR;
      end else begin
        s1_row_q   <= frame_top_q[COORD_BITS-1:0] + cur_row_q[COORD_BITS-1:0];
        s1_col_q   <= frame_left_q[COORD_BITS-1:0] + cur_col_q[COORD_BITS-1:0];
        s1_alpha_q <= (transp_on_q && (in_code == transp_index_q)) ?
                      ippw_pkg::ALPHA_CLEAR : ippw_pkg::ALPHA_OPAQUE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_bad_q   <= s1_bad_q;
      out_row_q   <= s1_row_q;
      out_col_q   <= s1_col_q;
      out_alpha_q <= s1_alpha_q;
      out_rgb_q   <= s1_bad_q ? '0 : pal_rd_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_bad_q;
  assign m_axis_tdata  = TdataW'({out_alpha_q, out_rgb_q[7:0], out_rgb_q[15:8],
                                  out_rgb_q[23:16], out_col_q, out_row_q});

  // Only pixel transactions fill the read stage.
  `IPPW_ASSERT_NEXT(a_s1_fill, s_acc, s1_v_q == $past(is_pixel), "read stage fill mismatch")
  // A waiting read stage entry is never dropped.
  `IPPW_ASSERT_NEXT(a_s1_hold, s1_v_q && !s1_move, s1_v_q, "read stage entry lost")
  // A rejected pixel carries an all-zero color.
  `IPPW_ASSERT(a_bad_zero, out_v_q && out_bad_q |-> (out_rgb_q == '0) && (out_alpha_q == '0),
               "bad pixel with nonzero color")
  // Interlace pass and row step stay paired.
  `IPPW_ASSERT(a_pass_step,
               ((pass_q == ippw_pkg::PASS_FIRST) && (step_q == ippw_pkg::STEP_FIRST)) ||
               ((pass_q == ippw_pkg::PASS_SECOND) && (step_q == ippw_pkg::STEP_SECOND)) ||
               ((pass_q == ippw_pkg::PASS_THIRD) && (step_q == ippw_pkg::STEP_THIRD)) ||
               ((pass_q == ippw_pkg::PASS_LAST) && (step_q == ippw_pkg::STEP_LAST)),
               "interlace pass and row step disagree")

endmodule
